// ===== sv/bdhd_pkg.sv =====
package bdhd_pkg;

  localparam int CFG_ADDR_W = 5;

  localparam logic [2:0] REG_SOURCE_WIDTH  = 3'd0;
  localparam logic [2:0] REG_SOURCE_HEIGHT = 3'd1;
  localparam logic [2:0] REG_THUMB_WIDTH   = 3'd2;
  localparam logic [2:0] REG_THUMB_HEIGHT  = 3'd3;
  localparam logic [2:0] REG_SCALE_INVERSE = 3'd4;
  localparam logic [2:0] REG_TWO_BIT       = 3'd5;

  localparam logic [31:0] HASH_X    = 32'd374761393;
  localparam logic [31:0] HASH_Y    = 32'd668265263;
  localparam logic [31:0] HASH_MIX  = 32'd1274126177;
  localparam logic [31:0] SCALE_ONE = 32'd65536;

  localparam logic [13:0] MAX_SOURCE_WIDTH = 14'd8192;
  localparam logic [7:0]  GRAY_STEP_2BIT   = 8'd85;
  localparam logic [7:0]  GRAY_WHITE_1BIT  = 8'd255;
  localparam logic [7:0]  THRESHOLD_MID    = 8'd128;

  localparam int PROD_W = 38;

  typedef struct packed {
    logic [12:0] x;
    logic [15:0] y;
    logic [13:0] col_span;
    logic [15:0] row_span;
  } dec_req_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_DECIDE,
    S_OUT
  } ctl_state_t;

  typedef enum logic [2:0] {
    D_IDLE,
    D_MUL1,
    D_MUL2,
    D_MIX,
    D_THR,
    D_PROD,
    D_CMP
  } dec_state_t;

endpackage

// ===== sv/box_downscale_hash_dither_core.sv =====
// Box-filter thumbnail downscaler with hashed threshold dither. Source pixels enter one word at a
// time in top-down raster order; each is added into its output column's running sum, held in a
// single-port sum memory of MAX_THUMB_WIDTH entries, and the last pixel of each output cell
// yields one dithered result word. A pixel is accepted with its memory read, then read-modify-written;
// a pixel that closes a cell then passes through the threshold and compare unit, plus any wait for
// the result register to drain. Writing a register restarts the frame, as does frame_start, and the
// block holds off the next pixel while the restart from a write is pending.
module box_downscale_hash_dither_core import bdhd_pkg::*; #(
  parameter int MAX_THUMB_WIDTH = 1024,
  parameter int SUM_WIDTH       = 32
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [CFG_ADDR_W-1:0] paddr,
  input  logic [31:0]           pwdata,
  output logic [31:0]           prdata,
  output logic                  pready,
  input  logic                  pixel_valid,
  output logic                  pixel_ready,
  input  logic [1:0]            pixel_value,
  input  logic                  frame_start,
  output logic                  result_valid,
  input  logic                  result_ready,
  output logic                  out_bit,
  output logic [9:0]            out_col,
  output logic [15:0]           out_row,
  output logic                  row_last,
  output logic                  frame_last
);

  localparam int CNT_W  = $clog2(MAX_THUMB_WIDTH + 1);
  localparam int ADDR_W = (MAX_THUMB_WIDTH > 1) ? $clog2(MAX_THUMB_WIDTH) : 1;
  localparam int CACC_W = CNT_W + 33;
  localparam int RACC_W = 49;

  logic [13:0] source_width;
  logic [15:0] source_height;
  logic [10:0] thumb_width;
  logic [15:0] thumb_height;
  logic [31:0] scale_inverse;
  logic        two_bit_source;
  logic        restart_pend;

  logic [13:0]      eff_w;
  logic [15:0]      eff_h, eff_th;
  logic [CNT_W-1:0] eff_tw;
  logic [10:0]      tw_raw;
  logic [31:0]      eff_scale;
  logic [13:0]      col_end_init;
  logic [15:0]      row_end_init;

  logic cfg_wr, cfg_hit;

  ctl_state_t st, st_next;

  logic [12:0]       src_col, src_col_next;
  logic [15:0]       src_row, src_row_next;
  logic [CNT_W-1:0]  cur_out_col, cur_out_col_next;
  logic [15:0]       cur_out_row, cur_out_row_next;
  logic [13:0]       col_start, col_start_next;
  logic [13:0]       col_span_end, col_span_end_next;
  logic [CACC_W-1:0] col_acc, col_acc_next;
  logic [15:0]       row_span_start, row_span_start_next;
  logic [15:0]       row_span_end, row_span_end_next;
  logic [RACC_W-1:0] row_acc, row_acc_next;
  logic [1:0]        pix_q;

  logic [SUM_WIDTH-1:0] sum_mem [MAX_THUMB_WIDTH];
  logic [SUM_WIDTH-1:0] rdata, base, sum_new;
  logic [SUM_WIDTH:0]   sum_add;
  logic [ADDR_W-1:0]    raddr;
  logic                 mem_we;

  logic       acc_in, slot_free;
  logic       row_act, col_act, active, col_done, row_done, emit;
  logic [7:0] gray;
  logic       rlast, flast;

  dec_req_t dec_req;
  logic     dec_done, dec_white;
  logic     white_q;
  logic [9:0]  meta_col;
  logic [15:0] meta_row;
  logic        meta_rlast, meta_flast;

  // Effective configuration after clamping out-of-range values.
  always_comb begin
    if (source_width == 14'd0) begin
      eff_w = 14'd1;
    end else if (source_width > MAX_SOURCE_WIDTH) begin
      eff_w = MAX_SOURCE_WIDTH;
    end else begin
      eff_w = source_width;
    end
    eff_h  = (source_height == 16'd0) ? 16'd1 : source_height;
    eff_th = (thumb_height == 16'd0) ? 16'd1 : thumb_height;
    tw_raw = (thumb_width == 11'd0) ? 11'd1 : thumb_width;
    if (32'(tw_raw) > 32'(MAX_THUMB_WIDTH)) begin
      eff_tw = CNT_W'(MAX_THUMB_WIDTH);
    end else begin
      eff_tw = CNT_W'(tw_raw);
    end
    eff_scale    = (scale_inverse < SCALE_ONE) ? SCALE_ONE : scale_inverse;
    col_end_init = (eff_scale[31:16] > 16'(eff_w)) ? eff_w : eff_scale[29:16];
    row_end_init = (eff_scale[31:16] > eff_h) ? eff_h : eff_scale[31:16];
  end

  always_comb begin
    pready  = 1'b1;
    cfg_wr  = psel && penable && pwrite;
    cfg_hit = (paddr[4:2] == REG_SOURCE_WIDTH) || (paddr[4:2] == REG_SOURCE_HEIGHT) ||
              (paddr[4:2] == REG_THUMB_WIDTH) || (paddr[4:2] == REG_THUMB_HEIGHT) ||
              (paddr[4:2] == REG_SCALE_INVERSE) || (paddr[4:2] == REG_TWO_BIT);
    unique case (paddr[4:2])
      REG_SOURCE_WIDTH:  prdata = 32'(source_width);
      REG_SOURCE_HEIGHT: prdata = 32'(source_height);
      REG_THUMB_WIDTH:   prdata = 32'(thumb_width);
      REG_THUMB_HEIGHT:  prdata = 32'(thumb_height);
      REG_SCALE_INVERSE: prdata = scale_inverse;
      REG_TWO_BIT:       prdata = 32'(two_bit_source);
      default:           prdata = 32'd0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      source_width   <= 14'd1;
      source_height  <= 16'd1;
      thumb_width    <= 11'd1;
      thumb_height   <= 16'd1;
      scale_inverse  <= SCALE_ONE;
      two_bit_source <= 1'b0;
      restart_pend   <= 1'b0;
    end else begin
      restart_pend <= cfg_wr && cfg_hit;
      if (cfg_wr) begin
        unique case (paddr[4:2])
          REG_SOURCE_WIDTH:  source_width   <= pwdata[13:0];
          REG_SOURCE_HEIGHT: source_height  <= pwdata[15:0];
          REG_THUMB_WIDTH:   thumb_width    <= pwdata[10:0];
          REG_THUMB_HEIGHT:  thumb_height   <= pwdata[15:0];
          REG_SCALE_INVERSE: scale_inverse  <= pwdata;
          REG_TWO_BIT:       two_bit_source <= pwdata[0];
          default: ;
        endcase
      end
    end
  end

  // Handshake outputs.
  always_comb begin
    pixel_ready = (st == S_IDLE) && !restart_pend;
    slot_free   = !result_valid || result_ready;
  end

  assign acc_in = pixel_valid && pixel_ready;

  // Datapath of one pixel step.
  always_comb begin
    row_act  = (cur_out_row < eff_th) && (row_span_start < eff_h);
    col_act  = (cur_out_col < eff_tw) && (col_start < eff_w);
    active   = row_act && col_act && (src_row < eff_h);
    col_done = (14'(src_col) + 14'd1) >= col_span_end;
    row_done = (17'(src_row) + 17'd1) >= 17'(row_span_end);
    emit     = (st == S_EXEC) && active && col_done && row_done;

    if (two_bit_source) begin
      gray = 8'(pix_q) * GRAY_STEP_2BIT;
    end else begin
      gray = pix_q[0] ? GRAY_WHITE_1BIT : 8'd0;
    end
    // The first pixel of a cell starts its column sum from zero.
    base    = ((src_row == row_span_start) && (14'(src_col) == col_start)) ? '0 : rdata;
    sum_add = {1'b0, base} + (SUM_WIDTH + 1)'(gray);
    sum_new = sum_add[SUM_WIDTH] ? '1 : sum_add[SUM_WIDTH-1:0];
    mem_we  = (st == S_EXEC) && active;
    raddr   = frame_start ? '0 : cur_out_col[ADDR_W-1:0];

    rlast = ((CNT_W + 1)'(cur_out_col) + (CNT_W + 1)'(1) == (CNT_W + 1)'(eff_tw)) ||
            (col_span_end >= eff_w);
    flast = rlast && (((17'(cur_out_row) + 17'd1) == 17'(eff_th)) ||
                      (row_span_end >= eff_h));

    dec_req.x        = 13'(cur_out_col);
    dec_req.y        = cur_out_row;
    dec_req.col_span = col_span_end - col_start;
    dec_req.row_span = row_span_end - row_span_start;
  end

  // Next values of the position and span state.
  always_comb begin
    src_col_next        = src_col;
    src_row_next        = src_row;
    cur_out_col_next    = cur_out_col;
    cur_out_row_next    = cur_out_row;
    col_start_next      = col_start;
    col_span_end_next   = col_span_end;
    col_acc_next        = col_acc;
    row_span_start_next = row_span_start;
    row_span_end_next   = row_span_end;
    row_acc_next        = row_acc;
    if (restart_pend || (acc_in && frame_start)) begin
      src_col_next        = '0;
      src_row_next        = '0;
      cur_out_col_next    = '0;
      cur_out_row_next    = '0;
      col_start_next      = '0;
      col_span_end_next   = col_end_init;
      col_acc_next        = CACC_W'(eff_scale);
      row_span_start_next = '0;
      row_span_end_next   = row_end_init;
      row_acc_next        = RACC_W'(eff_scale);
    end else if ((st == S_EXEC) && (src_row < eff_h)) begin
      if (active && col_done) begin
        cur_out_col_next = cur_out_col + CNT_W'(1);
        col_start_next   = col_span_end;
        col_acc_next     = col_acc + CACC_W'(eff_scale);
        if (col_acc_next[CACC_W-1:16] > (CACC_W - 16)'(eff_w)) begin
          col_span_end_next = eff_w;
        end else begin
          col_span_end_next = col_acc_next[29:16];
        end
      end
      if ((14'(src_col) + 14'd1) >= eff_w) begin
        src_col_next      = '0;
        src_row_next      = src_row + 16'd1;
        cur_out_col_next  = '0;
        col_start_next    = '0;
        col_acc_next      = CACC_W'(eff_scale);
        col_span_end_next = col_end_init;
        if (row_act && row_done) begin
          cur_out_row_next    = cur_out_row + 16'd1;
          row_span_start_next = row_span_end;
          row_acc_next        = row_acc + RACC_W'(eff_scale);
          if (row_acc_next[RACC_W-1:16] > (RACC_W - 16)'(eff_h)) begin
            row_span_end_next = eff_h;
          end else begin
            row_span_end_next = row_acc_next[31:16];
          end
        end
      end else begin
        src_col_next = src_col + 13'd1;
      end
    end
  end

  always_comb begin
    st_next = st;
    unique case (st)
      S_IDLE:   if (acc_in) st_next = S_EXEC;
      S_EXEC:   st_next = emit ? S_DECIDE : S_IDLE;
      S_DECIDE: if (dec_done) st_next = S_OUT;
      S_OUT:    if (slot_free) st_next = S_IDLE;
      default:  st_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st             <= S_IDLE;
      src_col        <= '0;
      src_row        <= '0;
      cur_out_col    <= '0;
      cur_out_row    <= '0;
      col_start      <= '0;
      col_span_end   <= 14'd1;
      col_acc        <= CACC_W'(SCALE_ONE);
      row_span_start <= '0;
      row_span_end   <= 16'd1;
      row_acc        <= RACC_W'(SCALE_ONE);
      result_valid   <= 1'b0;
    end else begin
      st             <= st_next;
      src_col        <= src_col_next;
      src_row        <= src_row_next;
      cur_out_col    <= cur_out_col_next;
      cur_out_row    <= cur_out_row_next;
      col_start      <= col_start_next;
      col_span_end   <= col_span_end_next;
      col_acc        <= col_acc_next;
      row_span_start <= row_span_start_next;
      row_span_end   <= row_span_end_next;
      row_acc        <= row_acc_next;
      if ((st == S_OUT) && slot_free) begin
        result_valid <= 1'b1;
      end else if (result_ready) begin
        result_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      sum_mem[cur_out_col[ADDR_W-1:0]] <= sum_new;
    end
    if (acc_in) begin
      rdata <= sum_mem[raddr];
      pix_q <= pixel_value;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      meta_col   <= 10'(cur_out_col);
      meta_row   <= cur_out_row;
      meta_rlast <= rlast;
      meta_flast <= flast;
    end
    if ((st == S_DECIDE) && dec_done) begin
      white_q <= dec_white;
    end
    if ((st == S_OUT) && slot_free) begin
      out_bit    <= white_q;
      out_col    <= meta_col;
      out_row    <= meta_row;
      row_last   <= meta_rlast;
      frame_last <= meta_flast;
    end
  end

  bdhd_decide #(
    .SUM_WIDTH(SUM_WIDTH)
  ) u_decide (
    .clk   (clk),
    .rst   (rst),
    .start (emit),
    .req   (dec_req),
    .sum   (sum_new),
    .done  (dec_done),
    .white (dec_white)
  );

endmodule

// ===== sv/bdhd_decide.sv =====
module bdhd_decide import bdhd_pkg::*; #(
  parameter int SUM_WIDTH = 32
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  input  dec_req_t             req,
  input  logic [SUM_WIDTH-1:0] sum,
  output logic                 done,
  output logic                 white
);

  localparam int CMP_W = (SUM_WIDTH > PROD_W) ? SUM_WIDTH : PROD_W;

  dec_state_t st, st_next;

  dec_req_t              req_q;
  logic [SUM_WIDTH-1:0]  sum_q;
  logic [31:0]           pa, pb, hm;
  logic [29:0]           samples;
  logic [7:0]            thr;
  logic [PROD_W-1:0]     prod;

  logic [31:0] h_sum, h_mixed;
  logic [7:0]  hb, dn, thr_calc;

  always_comb begin
    h_sum   = pa + pb;
    h_mixed = h_sum ^ (h_sum >> 13);
    hb      = hm[31:24];
    dn      = THRESHOLD_MID - hb;
    if (hb[7]) begin
      thr_calc = THRESHOLD_MID + {2'b00, hb[6:1]};
    end else begin
      thr_calc = THRESHOLD_MID - (dn >> 1);
    end
  end

  always_comb begin
    st_next = st;
    unique case (st)
      D_IDLE: if (start) st_next = D_MUL1;
      D_MUL1: st_next = D_MUL2;
      D_MUL2: st_next = D_MIX;
      D_MIX:  st_next = D_THR;
      D_THR:  st_next = D_PROD;
      D_PROD: st_next = D_CMP;
      D_CMP:  st_next = D_IDLE;
      default: st_next = D_IDLE;
    endcase
  end

  always_comb begin
    done  = (st == D_CMP);
    white = CMP_W'(sum_q) >= CMP_W'(prod);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st <= D_IDLE;
    end else begin
      st <= st_next;
    end
  end

  always_ff @(posedge clk) begin
    case (st)
      D_IDLE: begin
        if (start) begin
          req_q <= req;
          sum_q <= sum;
        end
      end
      D_MUL1: begin
        pa      <= 32'(32'(req_q.x) * HASH_X);
        samples <= 30'(req_q.col_span) * 30'(req_q.row_span);
      end
      D_MUL2: pb   <= 32'(32'(req_q.y) * HASH_Y);
      D_MIX:  hm   <= h_mixed * HASH_MIX;
      D_THR:  thr  <= thr_calc;
      D_PROD: prod <= PROD_W'(thr) * PROD_W'(samples);
      default: ;
    endcase
  end

endmodule
